// File: hw/rtl/dual_axis_impedance_torque_macros.svh
// Assertion macros shared by the impedance torque RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DUAL_AXIS_IMPEDANCE_TORQUE_MACROS_SVH
`define DUAL_AXIS_IMPEDANCE_TORQUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DAIT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define DAIT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/dait_pkg.sv
// Shared types and constants of the impedance torque controller.
// No dependencies; used by every RTL file of the block.
package dait_pkg;

  // input opcodes
  localparam logic [1:0] OPC_POS  = 2'd0;
  localparam logic [1:0] OPC_VEL  = 2'd1;
  localparam logic [1:0] OPC_TICK = 2'd2;
  localparam logic [1:0] OPC_RSVD = 2'd3;

  // register indexes
  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KD     = 3'd1;
  localparam logic [2:0] REG_MG     = 3'd2;
  localparam logic [2:0] REG_TPOS0  = 3'd3;
  localparam logic [2:0] REG_TPOS1  = 3'd4;
  localparam logic [2:0] REG_TVEL0  = 3'd5;
  localparam logic [2:0] REG_TVEL1  = 3'd6;

  localparam logic [23:0] KP_RST    = 24'd32768;
  localparam logic [23:0] KD_RST    = 24'd5243;
  localparam logic [23:0] MG_RST    = 24'd197;
  localparam logic [31:0] TPOS_RST  = 32'd262144;

  localparam int AXIS_IDX_W = 3;           // covers up to eight axes
  localparam int DIV_NW     = 53;          // dividend bits
  localparam int DIV_DW     = 32;          // divisor bits
  localparam int DIV_CNT_W  = 6;

  localparam logic [34:0] SUM_CAP    = 35'h4_0000_0000;  // 4.0 in Q32
  localparam logic [29:0] PI4_Q30    = 30'd843314857;
  localparam logic [15:0] TORQUE_MAX = 16'd22938;
  localparam logic [36:0] ONE_Q16    = 37'd65536;
  localparam logic [32:0] SLOW_SPEED = 33'd4172;
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  // x / 5 == (x * EMA_RECIP) >> EMA_SH, exact for x < 2^34
  localparam logic [31:0] EMA_RECIP  = 32'hCCCC_CCCD;
  localparam int          EMA_SH     = 34;
  localparam logic [4:0]  MSG_BASE   = 5'd14;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_POS, OP_VEL_MUL, OP_DIV1_GO, OP_RAW_SAT, OP_DIV2_GO,
    OP_ACC_WR, OP_MUL_KP, OP_MUL_KD, OP_MUL_MG, OP_ACC, OP_MAG, OP_SC_HI,
    OP_SC_LO, OP_EMIT
  } dait_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_VEL_MUL, ST_VEL_CHK, ST_DIV1, ST_RAW, ST_AVG, ST_DIV2,
    ST_ACCW, ST_T_KP, ST_T_KD, ST_T_MG, ST_T_ACC, ST_T_MAG, ST_T_HI, ST_T_LO
  } dait_state_t;

  typedef struct packed {
    dait_op_t              op;
    logic [AXIS_IDX_W-1:0] ax;
  } dait_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_done;
    logic out_free;
  } dait_sts_t;

  typedef struct packed {
    logic [23:0]        kp;
    logic [23:0]        kd;
    logic [23:0]        mass_gain;
    logic signed [31:0] tpos0;
    logic signed [31:0] tpos1;
    logic signed [31:0] tvel0;
    logic signed [31:0] tvel1;
  } dait_cfg_t;

endpackage

// File: hw/rtl/dait_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on dait_pkg for widths.
module dait_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dait_pkg::DIV_NW-1:0]  dividend,
  input  logic [dait_pkg::DIV_DW-1:0]  divisor,
  output logic [dait_pkg::DIV_NW-1:0]  quotient,
  output logic                         done
);

  logic [dait_pkg::DIV_DW-1:0]    rem_r, rem_nxt;
  logic [dait_pkg::DIV_NW-1:0]    quo_r, quo_nxt;
  logic [dait_pkg::DIV_DW-1:0]    dvs_r;
  logic [dait_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [dait_pkg::DIV_DW:0]      trial;
  logic [dait_pkg::DIV_DW:0]      diff;

  assign trial = {rem_r, quo_r[dait_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[dait_pkg::DIV_DW]) begin
        rem_nxt = diff[dait_pkg::DIV_DW-1:0];
        quo_nxt = {quo_r[dait_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[dait_pkg::DIV_DW-1:0];
        quo_nxt = {quo_r[dait_pkg::DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == dait_pkg::DIV_CNT_W'(dait_pkg::DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dvs_r <= divisor;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: hw/rtl/dait_dp.sv
// Datapath: axis state, shared multiplier, divider and output register.
// Depends on dait_pkg and dait_div.
module dait_dp #(
  parameter int NUM_AXES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dait_pkg::dait_cmd_t  cmd,
  output dait_pkg::dait_sts_t  sts,
  input  dait_pkg::dait_cfg_t  cfg,
  input  logic signed [31:0]   item_value,
  input  logic [31:0]          item_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_axis,
  output logic [5:0]           out_msg,
  output logic signed [15:0]   out_torque,
  output logic                 out_last
);

  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  logic signed [31:0] pos_r [NUM_AXES];
  logic signed [31:0] vel_r [NUM_AXES];
  logic signed [31:0] acl_r [NUM_AXES];
  logic [31:0]        tim_r [NUM_AXES];

  logic signed [31:0] val_r;
  logic [31:0]        time_r;
  logic [31:0]        dt_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] raw_r;
  logic               qneg_r;
  logic [33:0]        avg_r;
  logic [31:0]        ema_r;
  logic signed [59:0] acc_r;
  logic [34:0]        mag_r;
  logic               sneg_r;
  logic [63:0]        sc_r;
  logic               tol_r, half_r;
  logic               sum_pend_r;

  logic               ov_r;
  logic               oax_r, olast_r;
  logic [5:0]         omsg_r;
  logic signed [15:0] otq_r;

  logic [AXW-1:0]     ax;
  logic signed [31:0] pos_rd, vel_rd, acl_rd, tpos, tvel;
  logic [31:0]        tim_rd;
  logic signed [32:0] pe, ve, ae, vdiff;
  logic [32:0]        pm, vm;
  logic               tol_c, half_c;
  logic signed [32:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [63:0] prod_c;
  logic [63:0]        prod_mag;
  logic signed [34:0] sum2;
  logic [34:0]        sum2_mag;
  logic [65:0]        ema_full;
  logic [59:0]        acc_mag;
  logic               div_go, div_done;
  logic [dait_pkg::DIV_NW-1:0] div_dvd, div_q;
  logic [dait_pkg::DIV_DW-1:0] div_dvs;
  logic signed [31:0] raw_c, acl_new;
  logic [63:0]        sc_sum;
  logic [64:0]        rnd;
  logic [17:0]        qsh;
  logic [15:0]        qc;
  logic signed [15:0] tq;
  logic               last_ax;

  assign ax     = cmd.ax[AXW-1:0];
  assign pos_rd = pos_r[ax];
  assign vel_rd = vel_r[ax];
  assign acl_rd = acl_r[ax];
  assign tim_rd = tim_r[ax];
  assign tpos   = (cmd.ax == '0) ? cfg.tpos0 : cfg.tpos1;
  assign tvel   = (cmd.ax == '0) ? cfg.tvel0 : cfg.tvel1;

  assign pe    = 33'(tpos) - 33'(pos_rd);
  assign ve    = 33'(tvel) - 33'(vel_rd);
  assign ae    = 33'sd0 - 33'(acl_rd);
  assign vdiff = 33'(val_r) - 33'(vel_rd);
  assign pm    = pe[32] ? 33'(-pe) : 33'(pe);
  assign vm    = vel_rd[31] ? 33'(-33'(vel_rd)) : 33'(vel_rd);

  // tolerance band 1/9 turn, halving band under 1/3 turn at low speed
  assign tol_c  = ({pm, 3'b000} + 36'(pm)) <= 36'(dait_pkg::ONE_Q16);
  assign half_c = ({pm, 1'b0} + 34'(pm)) < 34'(dait_pkg::ONE_Q16) &&
                  vm <= dait_pkg::SLOW_SPEED;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      dait_pkg::OP_VEL_MUL: begin
        mul_a = vdiff;
        mul_b = $signed({11'b0, dait_pkg::US_PER_S});
      end
      dait_pkg::OP_MUL_KP: begin
        mul_a = pe;
        mul_b = $signed({7'b0, cfg.kp});
      end
      dait_pkg::OP_MUL_KD: begin
        mul_a = ve;
        mul_b = $signed({7'b0, cfg.kd});
      end
      dait_pkg::OP_MUL_MG: begin
        mul_a = ae;
        mul_b = $signed({7'b0, cfg.mass_gain});
      end
      dait_pkg::OP_SC_HI: begin
        mul_a = $signed({15'b0, mag_r[34:17]});
        mul_b = $signed({1'b0, dait_pkg::PI4_Q30});
      end
      dait_pkg::OP_SC_LO: begin
        mul_a = $signed({16'b0, mag_r[16:0]});
        mul_b = $signed({1'b0, dait_pkg::PI4_Q30});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c   = 64'(mul_a) * 64'(mul_b);
  assign prod_mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign sum2     = 35'(raw_r) + (35'(acl_rd) <<< 2);
  assign sum2_mag = sum2[34] ? 35'(-sum2) : 35'(sum2);
  assign acc_mag  = acc_r[59] ? 60'(-acc_r) : 60'(acc_r);

  // 1/5 smoothing by reciprocal multiply on the latched magnitude
  assign ema_full = 66'(avg_r) * 66'(dait_pkg::EMA_RECIP);

  assign div_go  = (cmd.op == dait_pkg::OP_DIV1_GO);
  assign div_dvd = prod_mag[dait_pkg::DIV_NW-1:0];
  assign div_dvs = dt_r;

  dait_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // saturate signed quotient to 32 bits
  always_comb begin
    if (qneg_r) begin
      raw_c = (div_q > dait_pkg::DIV_NW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                           : -$signed(div_q[31:0]);
    end else begin
      raw_c = (div_q > dait_pkg::DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                         : $signed(div_q[31:0]);
    end
  end
  assign acl_new = qneg_r ? -$signed(ema_r) : $signed(ema_r);

  // full scaled magnitude: high partial product plus low partial product
  assign sc_sum = sc_r + $unsigned(prod_r);

  // round half away from zero, clamp, apply sign
  assign rnd = {1'b0, sc_r} + (half_r ? (65'd1 << 47) : (65'd1 << 46));
  assign qsh = half_r ? {1'b0, rnd[64:48]} : rnd[64:47];
  assign qc  = (qsh > 18'(dait_pkg::TORQUE_MAX)) ? dait_pkg::TORQUE_MAX : qsh[15:0];
  assign tq  = tol_r ? 16'sd0 : (sneg_r ? -$signed(qc) : $signed(qc));
  assign last_ax = (ax == AXW'(NUM_AXES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        acl_r[i] <= '0;
        tim_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        dait_pkg::OP_POS: pos_r[ax] <= val_r;
        dait_pkg::OP_VEL_MUL: begin
          vel_r[ax] <= val_r;
          tim_r[ax] <= time_r;
        end
        dait_pkg::OP_ACC_WR: acl_r[ax] <= acl_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    ema_r  <= ema_full[dait_pkg::EMA_SH +: 32];
    case (cmd.op)
      dait_pkg::OP_LATCH: begin
        val_r  <= item_value;
        time_r <= item_time;
      end
      dait_pkg::OP_VEL_MUL: dt_r <= time_r - tim_rd;
      dait_pkg::OP_DIV1_GO: qneg_r <= prod_r[63];
      dait_pkg::OP_RAW_SAT: raw_r <= raw_c;
      dait_pkg::OP_DIV2_GO: begin
        qneg_r <= sum2[34];
        avg_r  <= sum2_mag[33:0];
      end
      dait_pkg::OP_MUL_KP: begin
        tol_r  <= tol_c;
        half_r <= half_c;
      end
      dait_pkg::OP_MUL_KD: acc_r <= 60'(prod_r);
      dait_pkg::OP_MUL_MG: acc_r <= acc_r + 60'(prod_r);
      dait_pkg::OP_ACC: acc_r <= acc_r + 60'(prod_r);
      dait_pkg::OP_MAG: begin
        sneg_r <= acc_r[59];
        mag_r  <= (acc_mag > 60'(dait_pkg::SUM_CAP)) ? dait_pkg::SUM_CAP : acc_mag[34:0];
      end
      dait_pkg::OP_SC_LO: sc_r <= {prod_r[46:0], 17'b0};
      dait_pkg::OP_EMIT: begin
        oax_r   <= ax[0];
        omsg_r  <= {ax[0], dait_pkg::MSG_BASE};
        otq_r   <= tq;
        olast_r <= last_ax;
      end
      default: ;
    endcase
    // low partial product lands in the cycle after the high one
    if (cmd.op == dait_pkg::OP_MAG) sc_r <= '0;
    if (sum_pend_r) sc_r <= sc_sum;
    if (cmd.op == dait_pkg::OP_ACC_WR) raw_r <= raw_r;
  end

  // sc sum: the low partial product is added while the ctrl waits to emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_pend_r <= 1'b0;
    end else begin
      sum_pend_r <= (cmd.op == dait_pkg::OP_SC_LO);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == dait_pkg::OP_EMIT) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign sts.dt_zero  = (dt_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = (!ov_r || out_ready) && !sum_pend_r;

  assign out_valid  = ov_r;
  assign out_axis   = oax_r;
  assign out_msg    = omsg_r;
  assign out_torque = otq_r;
  assign out_last   = olast_r;

endmodule

// File: hw/rtl/dait_ctrl.sv
// Controller state machine: sequences the datapath per transaction.
// Depends on dait_pkg.
module dait_ctrl #(
  parameter int NUM_AXES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_opcode,
  input  logic                 in_axis,
  output logic                 in_ready,
  output dait_pkg::dait_cmd_t  cmd,
  input  dait_pkg::dait_sts_t  sts
);

  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  dait_pkg::dait_state_t state_r, state_nxt;
  logic [AXW-1:0]        ax_r, ax_nxt;
  logic                  ax_ok;
  logic                  emit_r, emit_nxt;

  assign ax_ok = (int'(in_axis) < NUM_AXES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dait_pkg::ST_IDLE;
      ax_r    <= '0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    emit_nxt  = emit_r;
    in_ready  = 1'b0;
    cmd.op    = dait_pkg::OP_NONE;
    cmd.ax    = dait_pkg::AXIS_IDX_W'(ax_r);
    case (state_r)
      dait_pkg::ST_IDLE: begin
        in_ready = !emit_r;
        if (emit_r) begin
          // output wait after the scale steps
          if (sts.out_free) begin
            cmd.op   = dait_pkg::OP_EMIT;
            emit_nxt = 1'b0;
            if (ax_r != AXW'(NUM_AXES - 1)) begin
              ax_nxt    = ax_r + 1'b1;
              state_nxt = dait_pkg::ST_T_KP;
            end
          end
        end else if (in_valid) begin
          cmd.op = dait_pkg::OP_LATCH;
          ax_nxt = AXW'(in_axis);
          case (in_opcode)
            dait_pkg::OPC_POS:  if (ax_ok) state_nxt = dait_pkg::ST_POS;
            dait_pkg::OPC_VEL:  if (ax_ok) state_nxt = dait_pkg::ST_VEL_MUL;
            dait_pkg::OPC_TICK: begin
              ax_nxt    = '0;
              state_nxt = dait_pkg::ST_T_KP;
            end
            default: state_nxt = dait_pkg::ST_IDLE;
          endcase
        end
      end
      dait_pkg::ST_POS: begin
        cmd.op    = dait_pkg::OP_POS;
        state_nxt = dait_pkg::ST_IDLE;
      end
      dait_pkg::ST_VEL_MUL: begin
        cmd.op    = dait_pkg::OP_VEL_MUL;
        state_nxt = dait_pkg::ST_VEL_CHK;
      end
      dait_pkg::ST_VEL_CHK: begin
        if (sts.dt_zero) begin
          state_nxt = dait_pkg::ST_IDLE;
        end else begin
          cmd.op    = dait_pkg::OP_DIV1_GO;
          state_nxt = dait_pkg::ST_DIV1;
        end
      end
      dait_pkg::ST_DIV1: if (sts.div_done) state_nxt = dait_pkg::ST_RAW;
      dait_pkg::ST_RAW: begin
        cmd.op    = dait_pkg::OP_RAW_SAT;
        state_nxt = dait_pkg::ST_AVG;
      end
      dait_pkg::ST_AVG: begin
        cmd.op    = dait_pkg::OP_DIV2_GO;
        state_nxt = dait_pkg::ST_DIV2;
      end
      // wait state while the reciprocal product is registered
      dait_pkg::ST_DIV2: state_nxt = dait_pkg::ST_ACCW;
      dait_pkg::ST_ACCW: begin
        cmd.op    = dait_pkg::OP_ACC_WR;
        state_nxt = dait_pkg::ST_IDLE;
      end
      dait_pkg::ST_T_KP: begin
        cmd.op    = dait_pkg::OP_MUL_KP;
        state_nxt = dait_pkg::ST_T_KD;
      end
      dait_pkg::ST_T_KD: begin
        cmd.op    = dait_pkg::OP_MUL_KD;
        state_nxt = dait_pkg::ST_T_MG;
      end
      dait_pkg::ST_T_MG: begin
        cmd.op    = dait_pkg::OP_MUL_MG;
        state_nxt = dait_pkg::ST_T_ACC;
      end
      dait_pkg::ST_T_ACC: begin
        cmd.op    = dait_pkg::OP_ACC;
        state_nxt = dait_pkg::ST_T_MAG;
      end
      dait_pkg::ST_T_MAG: begin
        cmd.op    = dait_pkg::OP_MAG;
        state_nxt = dait_pkg::ST_T_HI;
      end
      dait_pkg::ST_T_HI: begin
        cmd.op    = dait_pkg::OP_SC_HI;
        state_nxt = dait_pkg::ST_T_LO;
      end
      dait_pkg::ST_T_LO: begin
        cmd.op    = dait_pkg::OP_SC_LO;
        emit_nxt  = 1'b1;
        state_nxt = dait_pkg::ST_IDLE;
      end
      default: state_nxt = dait_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/dual_axis_impedance_torque.sv
// Top level of the two-axis impedance torque controller.
// Depends on dait_pkg, dait_ctrl, dait_dp and the assertion macro header.
//
// Stream in: position samples, velocity samples with microsecond stamps,
// and control ticks. A tick returns one torque transaction per axis, axis 0
// first, with tlast on the final one. A position sample is latched and then
// written; a velocity sample makes one 53-step pass of the bit-serial divider
// for rate over elapsed time, then the 1/5 smoothing by a reciprocal
// multiply, and skips both when the elapsed time is zero. Per axis, a tick
// uses the single shared 33x31 multiplier five times, adds the scale partial
// products and waits on the output register while it is busy. The user must
// write registers over the APB-style port only while no work is pending;
// the block itself does not enforce this.
`include "dual_axis_impedance_torque_macros.svh"
module dual_axis_impedance_torque #(
  parameter int NUM_AXES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] sample_value, [63:32] time_us
  input  logic [2:0]  in_tuser,   // [1:0] opcode, [2] axis
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [5:0] message_id, [21:6] torque, [23:22] zero
  output logic        out_tuser,  // [0] out_axis
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dait_pkg::dait_cfg_t cfg_r;
  dait_pkg::dait_cmd_t cmd;
  dait_pkg::dait_sts_t sts;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;
  logic [5:0]          msg;
  logic signed [15:0]  torque;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  // register file; gains keep the low 24 bits of the write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= dait_pkg::KP_RST;
      cfg_r.kd        <= dait_pkg::KD_RST;
      cfg_r.mass_gain <= dait_pkg::MG_RST;
      cfg_r.tpos0     <= $signed(dait_pkg::TPOS_RST);
      cfg_r.tpos1     <= $signed(dait_pkg::TPOS_RST);
      cfg_r.tvel0     <= '0;
      cfg_r.tvel1     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dait_pkg::REG_KP:    cfg_r.kp        <= cfg_pwdata[23:0];
        dait_pkg::REG_KD:    cfg_r.kd        <= cfg_pwdata[23:0];
        dait_pkg::REG_MG:    cfg_r.mass_gain <= cfg_pwdata[23:0];
        dait_pkg::REG_TPOS0: cfg_r.tpos0     <= $signed(cfg_pwdata);
        dait_pkg::REG_TPOS1: cfg_r.tpos1     <= $signed(cfg_pwdata);
        dait_pkg::REG_TVEL0: cfg_r.tvel0     <= $signed(cfg_pwdata);
        dait_pkg::REG_TVEL1: cfg_r.tvel1     <= $signed(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dait_pkg::REG_KP:    cfg_prdata = {8'b0, cfg_r.kp};
      dait_pkg::REG_KD:    cfg_prdata = {8'b0, cfg_r.kd};
      dait_pkg::REG_MG:    cfg_prdata = {8'b0, cfg_r.mass_gain};
      dait_pkg::REG_TPOS0: cfg_prdata = cfg_r.tpos0;
      dait_pkg::REG_TPOS1: cfg_prdata = cfg_r.tpos1;
      dait_pkg::REG_TVEL0: cfg_prdata = cfg_r.tvel0;
      dait_pkg::REG_TVEL1: cfg_prdata = cfg_r.tvel1;
      default:             cfg_prdata = '0;
    endcase
  end

  dait_ctrl #(.NUM_AXES(NUM_AXES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser[1:0]),
    .in_axis   (in_tuser[2]),
    .in_ready  (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dait_dp #(.NUM_AXES(NUM_AXES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg_r),
    .item_value ($signed(in_tdata[31:0])),
    .item_time  (in_tdata[63:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_axis   (out_tuser),
    .out_msg    (msg),
    .out_torque (torque),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, torque, msg};

  // torque never leaves the clamp range
  `DAIT_ASSERT_IMP(a_torque_range, clk, rst_n, out_tvalid,
                   (torque <= 16'sd22938) && (torque >= -16'sd22938))
  // message id follows the axis tag
  `DAIT_ASSERT_IMP(a_msg_id, clk, rst_n, out_tvalid,
                   (msg[4:0] == dait_pkg::MSG_BASE) && (msg[5] == out_tuser))
  // a reserved opcode leaves the block ready in the next cycle
  `DAIT_ASSERT_NXT(a_rsvd_op, clk, rst_n,
                   in_tvalid && in_tready && (in_tuser[1:0] == dait_pkg::OPC_RSVD),
                   in_tready)

endmodule

// File: tb/dait_torque_sb.sv
// Scoreboard for the two-axis impedance torque controller: predicts torque
// results from the input transactions. Depends on dait_pkg only.
`timescale 1ns / 100ps
class dait_torque_sb;
  // shadow configuration
  logic [23:0] kp, kd, mass_gain;
  logic signed [31:0] tpos [2];
  logic signed [31:0] tvel [2];
  // shadow controller state
  longint position [2];
  longint velocity [2];
  longint accel [2];
  logic [31:0] stamp [2];
  // expected torque transactions: {axis, msg_id, torque, last}
  logic [23:0] torque_q [$];
  int errors;

  function void reset_state();
    kp = dait_pkg::KP_RST;
    kd = dait_pkg::KD_RST;
    mass_gain = dait_pkg::MG_RST;
    for (int a = 0; a < 2; a++) begin
      tpos[a] = dait_pkg::TPOS_RST;
      tvel[a] = '0;
      position[a] = 0;
      velocity[a] = 0;
      accel[a] = 0;
      stamp[a] = '0;
    end
    torque_q.delete();
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      dait_pkg::REG_KP:    kp = val[23:0];
      dait_pkg::REG_KD:    kd = val[23:0];
      dait_pkg::REG_MG:    mass_gain = val[23:0];
      dait_pkg::REG_TPOS0: tpos[0] = val;
      dait_pkg::REG_TPOS1: tpos[1] = val;
      dait_pkg::REG_TVEL0: tvel[0] = val;
      dait_pkg::REG_TVEL1: tvel[1] = val;
      default: ;
    endcase
  endfunction

  function logic [15:0] axis_torque(int a);
    longint pe, ve, ae, s, pm, m;
    logic [127:0] prod, q;
    int sh;
    pe = longint'(tpos[a]) - position[a];
    ve = longint'(tvel[a]) - velocity[a];
    ae = -accel[a];
    pm = pe < 0 ? -pe : pe;
    if (9 * pm <= 65536) return 16'd0;
    s = longint'(kp) * pe + longint'(kd) * ve + longint'(mass_gain) * ae;
    m = s < 0 ? -s : s;
    if (m > 64'h4_0000_0000) m = 64'h4_0000_0000;
    prod = 128'(m) * 128'(dait_pkg::PI4_Q30);
    sh = (3 * pm < 65536 && (velocity[a] < 0 ? -velocity[a] : velocity[a]) <= 4172)
         ? 48 : 47;
    q = (prod + (128'd1 << (sh - 1))) >> sh;
    if (q > 22938) q = 22938;
    return s < 0 ? 16'(-q[15:0]) : q[15:0];
  endfunction

  // note one accepted input transaction
  function void note_input(logic [1:0] op, logic ax, logic [31:0] val, logic [31:0] t);
    longint v, raw;
    logic [31:0] dt;
    v = longint'(signed'(val));
    case (op)
      dait_pkg::OPC_POS: position[ax] = v;
      dait_pkg::OPC_VEL: begin
        dt = t - stamp[ax];
        if (dt != 0) begin
          raw = ((v - velocity[ax]) * 1000000) / longint'(dt);
          if (raw > 64'sd2147483647) raw = 64'sd2147483647;
          if (raw < -64'sd2147483648) raw = -64'sd2147483648;
          accel[ax] = (raw + 4 * accel[ax]) / 5;
        end
        velocity[ax] = v;
        stamp[ax] = t;
      end
      dait_pkg::OPC_TICK:
        for (int a = 0; a < 2; a++)
          torque_q.push_back({1'(a), 6'((a << 5) | 14), axis_torque(a), a == 1});
      default: ;
    endcase
  endfunction

  // check one accepted result; returns a mismatch text or empty
  function string check_result(logic ax, logic [5:0] id, logic [15:0] tq, logic lst);
    logic [23:0] e;
    if (torque_q.size() == 0) return "result with nothing expected";
    e = torque_q.pop_front();
    if ({ax, id, tq, lst} !== e)
      return $sformatf("got axis %0d id %0d torque %0d last %0d, want %0d %0d %0d %0d",
                       ax, id, $signed(tq), lst, e[23], e[22:17], $signed(e[16:1]), e[0]);
    return "";
  endfunction
endclass

// File: tb/tb_top.sv
// Top-level testbench of the two-axis impedance torque controller.
// Depends on dait_pkg, dait_torque_sb and the block itself.
`timescale 1ns / 100ps
module tb_top;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [63:0] in_tdata;          // [31:0] sample_value, [63:32] time_us
  logic [2:0] in_tuser;           // [1:0] opcode, [2] axis
  logic out_tvalid, out_tready;
  logic [23:0] out_tdata;         // [5:0] message_id, [21:6] torque, [23:22] zero
  logic out_tuser;                // [0] out_axis
  logic out_tlast;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  dual_axis_impedance_torque dut (.*);

  dait_torque_sb sb;
  int fail_count;
  bit hold_off;       // long receiver stall request
  bit stim_done;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // safety net for the slowest run, stalls included
  initial begin
    #60ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // register write: setup then access cycle
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // one input transaction; leaves in_tvalid high, caller drops it at gaps
  task automatic send(logic [1:0] op, logic ax, logic [31:0] val, logic [31:0] t);
    in_tvalid <= 1;
    in_tuser <= {ax, op};
    in_tdata <= {t, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, ax, val, t);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_tvalid <= 0;
    repeat (n) @(negedge clk);
  endtask

  // block idle: queue drained, then the longest velocity pass
  task automatic drain();
    in_tvalid <= 0;
    while (sb.torque_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // random config; extremes mixed in
  function automatic logic [31:0] pick_reg(logic [2:0] idx);
    int k;
    k = $urandom_range(0, 5);
    if (idx <= dait_pkg::REG_MG)
      case (k)
        0: return 0;
        1: return 32'hFF_FFFF;
        default: return $urandom_range(0, 200000);
      endcase
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 600000) - 300000;
    endcase
  endfunction

  // near-target values mixed in so the tolerance and halving bands get hit
  function automatic logic [31:0] rand_val(logic [31:0] center);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return center + $urandom_range(0, 16000) - 8000;
      2: return center + $urandom_range(0, 60000) - 30000;
      default: return $urandom_range(0, 20000) - 10000;
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [1:0] op;
    logic ax;
    logic [31:0] t, v;
    int burst;
    t = $urandom;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 9) < 4 ? dait_pkg::OPC_VEL
           : ($urandom_range(0, 2) == 0 ? dait_pkg::OPC_TICK
           : ($urandom_range(0, 15) == 0 ? dait_pkg::OPC_RSVD : dait_pkg::OPC_POS));
      ax = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
        0: t = t;                       // zero elapsed time
        1: t = $urandom;                // arbitrary, may wrap
        default: t = t + $urandom_range(1, 5000);
      endcase
      v = op == dait_pkg::OPC_POS ? rand_val(sb.tpos[ax]) : rand_val(sb.tvel[ax]);
      send(op, ax, v, t);
      if (--burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  // receiver: own stall pattern plus a long hold-off on request
  initial begin
    int mode;
    out_tready = 0;
    forever begin
      @(negedge clk);
      mode = int'(($time / 20000) % 4);
      if (hold_off) out_tready <= 0;
      else if (mode == 0) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // output monitor
  initial begin
    string msg;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        msg = sb.check_result(out_tuser, out_tdata[5:0], out_tdata[21:6], out_tlast);
        if (msg != "") report(msg);
      end
    end
  end

  initial begin
    sb = new();
    sb.reset_state();
    fail_count = 0;
    hold_off = 0;
    stim_done = 0;
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset values, field extremes, bands, reserved opcode
    send(dait_pkg::OPC_TICK, 0, 0, 0);
    send(dait_pkg::OPC_POS, 0, 32'h7FFF_FFFF, 0);
    send(dait_pkg::OPC_POS, 1, 32'h8000_0000, 32'hFFFF_FFFF);
    send(dait_pkg::OPC_TICK, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(dait_pkg::OPC_POS, 0, 262144 - 7000, 0);     // inside tolerance
    send(dait_pkg::OPC_POS, 1, 262144 + 15000, 0);    // halving band
    send(dait_pkg::OPC_TICK, 0, 0, 0);
    send(dait_pkg::OPC_VEL, 0, 32'h7FFF_FFFF, 1);
    send(dait_pkg::OPC_VEL, 0, 32'h8000_0000, 2);     // saturated rate
    send(dait_pkg::OPC_VEL, 0, 1000, 2);              // zero elapsed time
    send(dait_pkg::OPC_VEL, 1, 4172, 32'hFFFF_FFFF);
    send(dait_pkg::OPC_VEL, 1, -4173, 32'h0000_0005); // wrapped stamp
    send(dait_pkg::OPC_RSVD, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(dait_pkg::OPC_POS, 0, 262144 + 30000, 0);
    send(dait_pkg::OPC_TICK, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      for (int r = dait_pkg::REG_KP; r <= dait_pkg::REG_TVEL1; r++) begin
        if (ph == 1)
          reg_write(3'(r), r <= dait_pkg::REG_MG ? 32'hFF_FFFF : 32'h7FFF_FFFF);
        else if (ph == 2)
          reg_write(3'(r), r <= dait_pkg::REG_MG ? 32'h0 : 32'h8000_0000);
        else if (ph == 8)
          reg_write(3'(r), r == dait_pkg::REG_KP ? dait_pkg::KP_RST
                    : r == dait_pkg::REG_KD ? dait_pkg::KD_RST
                    : r == dait_pkg::REG_MG ? dait_pkg::MG_RST
                    : r <= dait_pkg::REG_TPOS1 ? dait_pkg::TPOS_RST : 0);
        else reg_write(3'(r), pick_reg(3'(r)));
      end
      if (ph == 4) begin
        // long receiver hold-off while ticks keep arriving
        fork
          begin
            hold_off = 1;
            repeat (600) @(negedge clk);
            hold_off = 0;
          end
          random_phase(40);
        join
      end
      random_phase(145);
      drain();   // sender pauses until every result has come
    end

    stim_done = 1;
    repeat (200) @(negedge clk);
    if (fail_count == 0 && sb.torque_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.torque_q.size() != 0) report("expected torque results never came");
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
